@@ hw/rtl/smtp_pkg.sv @@
package smtp_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int WORD_W    = 64;
	localparam int ROOT_W    = 64;
	localparam int RAD_W     = 2 * ROOT_W;

	localparam logic [CFG_W-1:0]  CFG_RESET = 32'h0001_0000;
	// stand-in quotient for division by zero
	localparam logic [WORD_W-1:0] QUOT_CAP  = 64'h4000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_VELOCITY = 2'd0,
		REG_MAX_ACCEL    = 2'd1,
		REG_JERK_LIMIT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CASE_CRUISE = 2'd0,
		CASE_ACCEL  = 2'd1,
		CASE_JERK   = 2'd2
	} profile_t;

endpackage

@@ hw/rtl/smtp_div_cell.sv @@
module smtp_div_cell #(
	parameter int QW = 48
) (
	input  logic                       clk,
	input  logic [QW-1:0]              num_i,
	input  logic [smtp_pkg::CFG_W-1:0] rem_i,
	input  logic [smtp_pkg::CFG_W-1:0] den_i,
	output logic [QW-1:0]              num_o,
	output logic [smtp_pkg::CFG_W-1:0] rem_o,
	output logic [smtp_pkg::CFG_W-1:0] den_o
);
	import smtp_pkg::*;

	logic [CFG_W:0] trial;
	logic [CFG_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_i, num_i[QW-1]};
		diff  = trial - {1'b0, den_i};
		ge    = trial >= {1'b0, den_i};
	end

	// numerator bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		num_o <= {num_i[QW-2:0], ge};
		rem_o <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
		den_o <= den_i;
	end

endmodule

@@ hw/rtl/smtp_sqrt_cell.sv @@
module smtp_sqrt_cell (
	input  logic                          clk,
	input  logic [smtp_pkg::RAD_W-1:0]    rad_i,
	input  logic [smtp_pkg::ROOT_W+1:0]   rem_i,
	input  logic [smtp_pkg::ROOT_W-1:0]   root_i,
	output logic [smtp_pkg::RAD_W-1:0]    rad_o,
	output logic [smtp_pkg::ROOT_W+1:0]   rem_o,
	output logic [smtp_pkg::ROOT_W-1:0]   root_o
);
	import smtp_pkg::*;

	logic [ROOT_W+1:0] cur;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	always_comb begin
		cur   = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = cur >= trial;
	end

	always_ff @(posedge clk) begin
		rad_o  <= rad_i << 2;
		rem_o  <= ge ? cur - trial : cur;
		root_o <= {root_i[ROOT_W-2:0], ge};
	end

endmodule

@@ hw/rtl/scurve_move_time_planner.sv @@
// channel   direction  handshake          payload
// ---------------------------------------------------------------------------------
// command   in         start / busy       move_distance
// result    out        done (one cycle)   ramp_time cruise_time move_time
//                                         profile_case overflowed
// config    in         cfg_we             cfg_index cfg_wdata
//
// one item enters per cycle; busy stays low
// items pass one divider cell per quotient bit, the squaring stages,
// one root cell per root bit and the finish registers
// reset loads CFG_RESET into the configuration and clears all valid bits, not the data path
// the receiver cannot stall: done is high for exactly one cycle per item
module scurve_move_time_planner #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [31:0]                    move_distance,
	input  logic                           cfg_we,
	input  logic [smtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smtp_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                           done,
	output logic [31:0]                    ramp_time,
	output logic [31:0]                    cruise_time,
	output logic [31:0]                    move_time,
	output logic [1:0]                     profile_case,
	output logic                           overflowed
);
	import smtp_pkg::*;

	localparam int QW  = CFG_W + FRAC_BITS;
	localparam int LAT = QW + 5 + ROOT_W + 3;
	localparam int NDIV = 4;

	typedef struct packed {
		logic              case0;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
	} side_t;

	logic [CFG_W-1:0] vel_q, acc_q, jerk_q;
	logic [LAT-1:0]   vld_q;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q  <= CFG_RESET;
			acc_q  <= CFG_RESET;
			jerk_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_VELOCITY: vel_q  <= cfg_wdata;
				REG_MAX_ACCEL:    acc_q  <= cfg_wdata;
				REG_JERK_LIMIT:   jerk_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// dividers: a/j, v/a, p/v, p/a
	logic [QW-1:0]    num_w [NDIV][QW+1];
	logic [CFG_W-1:0] rem_w [NDIV][QW+1];
	logic [CFG_W-1:0] den_w [NDIV][QW+1];
	logic [CFG_W-1:0] num_src [NDIV];
	logic [CFG_W-1:0] den_src [NDIV];

	always_comb begin
		num_src[0] = acc_q;         den_src[0] = jerk_q;
		num_src[1] = vel_q;         den_src[1] = acc_q;
		num_src[2] = move_distance; den_src[2] = vel_q;
		num_src[3] = move_distance; den_src[3] = acc_q;
	end

	for (genvar u = 0; u < NDIV; u++) begin : g_div
		assign num_w[u][0] = {num_src[u], {FRAC_BITS{1'b0}}};
		assign rem_w[u][0] = '0;
		assign den_w[u][0] = den_src[u];
		for (genvar k = 0; k < QW; k++) begin : g_cell
			smtp_div_cell #(.QW(QW)) u_cell (
				.clk   (clk),
				.num_i (num_w[u][k]),
				.rem_i (rem_w[u][k]),
				.den_i (den_w[u][k]),
				.num_o (num_w[u][k+1]),
				.rem_o (rem_w[u][k+1]),
				.den_o (den_w[u][k+1])
			);
		end
	end

	logic [WORD_W-1:0] quot [NDIV];
	always_comb begin
		for (int u = 0; u < NDIV; u++) begin
			quot[u] = (den_w[u][QW] == '0) ? QUOT_CAP : WORD_W'(num_w[u][QW]);
		end
	end

	// stage 1: capped quotients
	logic [WORD_W-1:0] ta_s1, va_s1, pv_s1, q_s1, h_s1;
	always_ff @(posedge clk) begin
		ta_s1 <= quot[0];
		va_s1 <= quot[1];
		pv_s1 <= quot[2];
		q_s1  <= quot[3];
		h_s1  <= (den_w[3][QW] == '0) ? QUOT_CAP : WORD_W'(num_w[3][QW] >> 1);
	end

	// stage 2: ramp sum and low square term
	logic [WORD_W-1:0] s_s2, ta_s2, pv_s2, q_s2, h_s2, mll_s2;
	always_ff @(posedge clk) begin
		s_s2   <= ta_s1 + va_s1;
		mll_s2 <= ta_s1[31:0] * ta_s1[31:0];
		ta_s2  <= ta_s1;
		pv_s2  <= pv_s1;
		q_s2   <= q_s1;
		h_s2   <= h_s1;
	end

	// stage 3: cruise decision, cross term
	side_t             side_s3, side_s4, side_s5;
	logic [RAD_W-1:0]  acc_s3, acc_s4, rad_s5, hrad_s5;
	logic [WORD_W-1:0] mlh_s3, ta_s3, h_s3, h_s4;
	logic [61:0]       mhh_s4;
	logic              cruise_ok;

	assign cruise_ok = pv_s2 >= s_s2;

	always_ff @(posedge clk) begin
		side_s3.case0 <= cruise_ok;
		side_s3.w0    <= cruise_ok ? s_s2 : ta_s2;
		side_s3.w1    <= cruise_ok ? pv_s2 - s_s2 : '0;
		mlh_s3        <= WORD_W'(ta_s2[31:0] * ta_s2[62:32]);
		acc_s3        <= RAD_W'(mll_s2) + (RAD_W'(q_s2) << (FRAC_BITS + 2));
		ta_s3         <= ta_s2;
		h_s3          <= h_s2;
	end

	// stage 4 and 5: finish ta squared plus 4q
	always_ff @(posedge clk) begin
		mhh_s4  <= ta_s3[62:32] * ta_s3[62:32];
		acc_s4  <= acc_s3 + (RAD_W'(mlh_s3) << 33);
		side_s4 <= side_s3;
		h_s4    <= h_s3;
		rad_s5  <= acc_s4 + (RAD_W'(mhh_s4) << 64);
		hrad_s5 <= RAD_W'(h_s4) << FRAC_BITS;
		side_s5 <= side_s4;
	end

	// square roots of the discriminant and of h
	logic [RAD_W-1:0]  rad_w  [2][ROOT_W+1];
	logic [ROOT_W+1:0] srem_w [2][ROOT_W+1];
	logic [ROOT_W-1:0] root_w [2][ROOT_W+1];

	assign rad_w[0][0] = rad_s5;
	assign rad_w[1][0] = hrad_s5;

	for (genvar u = 0; u < 2; u++) begin : g_sqrt
		assign srem_w[u][0] = '0;
		assign root_w[u][0] = '0;
		for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
			smtp_sqrt_cell u_cell (
				.clk    (clk),
				.rad_i  (rad_w[u][k]),
				.rem_i  (srem_w[u][k]),
				.root_i (root_w[u][k]),
				.rad_o  (rad_w[u][k+1]),
				.rem_o  (srem_w[u][k+1]),
				.root_o (root_w[u][k+1])
			);
		end
	end

	side_t side_q [ROOT_W];
	always_ff @(posedge clk) begin
		side_q[0] <= side_s5;
		for (int k = 1; k < ROOT_W; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	// finish
	side_t             side_s6;
	logic [WORD_W+1:0] three_ta_s6;
	logic [WORD_W:0]   sum_s6;
	logic [ROOT_W-1:0] r_s6, sh_s6;
	logic [WORD_W-1:0] ramp_s7, cruise_s7;
	profile_t          pcase_s7;

	always_ff @(posedge clk) begin
		side_s6     <= side_q[ROOT_W-1];
		three_ta_s6 <= (WORD_W+2)'(side_q[ROOT_W-1].w0)
			+ ((WORD_W+2)'(side_q[ROOT_W-1].w0) << 1);
		sum_s6      <= (WORD_W+1)'(side_q[ROOT_W-1].w0) + (WORD_W+1)'(root_w[0][ROOT_W]);
		r_s6        <= root_w[0][ROOT_W];
		sh_s6       <= root_w[1][ROOT_W];
	end

	always_ff @(posedge clk) begin
		cruise_s7 <= side_s6.w1;
		if (side_s6.case0) begin
			pcase_s7 <= CASE_CRUISE;
			ramp_s7  <= side_s6.w0;
		end else if ((WORD_W+2)'(r_s6) < three_ta_s6) begin
			pcase_s7 <= CASE_JERK;
			ramp_s7  <= {sh_s6[ROOT_W-2:0], 1'b0};
		end else begin
			pcase_s7 <= CASE_ACCEL;
			ramp_s7  <= sum_s6[WORD_W:1];
		end
	end

	logic [WORD_W+1:0] total;
	logic              ramp_big, cruise_big, total_big;

	always_comb begin
		total      = ((WORD_W+2)'(ramp_s7) << 1) + (WORD_W+2)'(cruise_s7);
		ramp_big   = ramp_s7[WORD_W-1:32] != '0;
		cruise_big = cruise_s7[WORD_W-1:32] != '0;
		total_big  = total[WORD_W+1:32] != '0;
	end

	always_ff @(posedge clk) begin
		ramp_time    <= ramp_big ? '1 : ramp_s7[31:0];
		cruise_time  <= cruise_big ? '1 : cruise_s7[31:0];
		move_time    <= total_big ? '1 : total[31:0];
		profile_case <= pcase_s7;
		overflowed   <= ramp_big | cruise_big | total_big;
	end

	assign done = vld_q[LAT-1];

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("item did not complete at the pipeline depth");

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done && !overflowed |->
			{1'b0, move_time} == ({ramp_time, 1'b0} + {1'b0, cruise_time}))
		else $error("move time differs from twice ramp plus cruise");

	a_no_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		done && profile_case != CASE_CRUISE |-> cruise_time == '0)
		else $error("cruise time set on a profile without cruise");

endmodule
